/* rtl/segmented_multi_vector_store_core_defines.svh */
// Assertion macros shared by the segmented multi-vector store RTL.
`ifndef SEGMENTED_MULTI_VECTOR_STORE_CORE_DEFINES_SVH
`define SEGMENTED_MULTI_VECTOR_STORE_CORE_DEFINES_SVH

`ifndef SYNTH
`define SMVS_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define SMVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SMVS_ASSERT(label, cond)
`define SMVS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/smvs_pkg.sv */
// Package with constants, types and the capacity table of the segmented vector store.
package smvs_pkg;

  localparam int TILE_N      = 4096;
  localparam int MAX_VECTORS = 16;
  localparam int ADDR_W      = $clog2(TILE_N);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int WORD_W      = 16;
  localparam int VID_W       = 4;
  localparam int VEC_W       = 5;
  localparam int OP_W        = 3;

  localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
  localparam logic [OP_W-1:0] OP_READ      = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd5;

  localparam logic [CNT_W-1:0] CAP_TABLE [MAX_VECTORS+1] = '{
    CNT_W'(0),
    CNT_W'(TILE_N / 1),  CNT_W'(TILE_N / 2),  CNT_W'(TILE_N / 3),  CNT_W'(TILE_N / 4),
    CNT_W'(TILE_N / 5),  CNT_W'(TILE_N / 6),  CNT_W'(TILE_N / 7),  CNT_W'(TILE_N / 8),
    CNT_W'(TILE_N / 9),  CNT_W'(TILE_N / 10), CNT_W'(TILE_N / 11), CNT_W'(TILE_N / 12),
    CNT_W'(TILE_N / 13), CNT_W'(TILE_N / 14), CNT_W'(TILE_N / 15), CNT_W'(TILE_N / 16)
  };

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } ram_cmd_t;

  typedef struct packed {
    logic             accepted;
    logic             rd;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] cap;
  } res_info_t;

  function automatic logic [CNT_W-1:0] cap_of(input logic [VEC_W-1:0] n);
    logic [CNT_W-1:0] c;
    c = '0;
    if (n <= VEC_W'(MAX_VECTORS)) begin
      c = CAP_TABLE[n];
    end
    return c;
  endfunction

endpackage

/* rtl/smvs_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module smvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/smvs_issue.sv */
// Operation decode, fill counters, capacity register and store command generation.
module smvs_issue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [smvs_pkg::VEC_W-1:0]   cfg_wdata,
  input  logic                         fire,
  input  logic [smvs_pkg::OP_W-1:0]    op,
  input  logic [smvs_pkg::VID_W-1:0]   vector_id,
  input  logic [smvs_pkg::ADDR_W-1:0]  index,
  input  logic [smvs_pkg::WORD_W-1:0]  value,
  output smvs_pkg::ram_cmd_t           cmd,
  output smvs_pkg::res_info_t          info
);

  localparam int CW = smvs_pkg::CNT_W;
  localparam int AW = smvs_pkg::ADDR_W;
  localparam int PW = smvs_pkg::VID_W + CW;

  logic [smvs_pkg::VEC_W-1:0] vec_r;
  logic [CW-1:0]              cap_r;
  logic [CW-1:0]              cnt_r   [smvs_pkg::MAX_VECTORS];
  logic [CW-1:0]              cnt_nxt [smvs_pkg::MAX_VECTORS];

  logic          enabled;
  logic          vid_ok;
  logic          ok_out;
  logic          idx_ok;
  logic          acc;
  logic          clr_all;
  logic [CW-1:0] cnt_cur;
  logic [CW-1:0] cnt_new;
  logic [PW-1:0] prod;
  logic [AW-1:0] base;

  assign enabled = cap_r != '0;
  assign vid_ok  = enabled && ({1'b0, vector_id} < vec_r);
  assign cnt_cur = cnt_r[vector_id];
  assign prod    = PW'(vector_id) * PW'(cap_r);
  assign base    = prod[AW-1:0];
  assign idx_ok  = {1'b0, index} < cap_r;

  always_comb begin
    acc      = 1'b0;
    ok_out   = vid_ok;
    clr_all  = 1'b0;
    cnt_new  = cnt_cur;
    cmd      = '0;
    cmd.addr = base + index;
    cmd.wdata = value;
    unique case (op)
      smvs_pkg::OP_PUSH: begin
        acc      = vid_ok && (cnt_cur < cap_r);
        cmd.addr = base + cnt_cur[AW-1:0];
        cmd.en   = acc;
        cmd.we   = 1'b1;
        if (acc) begin
          cnt_new = cnt_cur + CW'(1);
        end
      end
      smvs_pkg::OP_READ: begin
        acc    = vid_ok && idx_ok;
        cmd.en = acc;
      end
      smvs_pkg::OP_WRITE: begin
        acc    = vid_ok && idx_ok;
        cmd.en = acc;
        cmd.we = 1'b1;
        if (acc && ({1'b0, index} >= cnt_cur)) begin
          cnt_new = {1'b0, index} + CW'(1);
        end
      end
      smvs_pkg::OP_CLEAR: begin
        acc = vid_ok;
        if (acc) begin
          cnt_new = '0;
        end
      end
      smvs_pkg::OP_CLEAR_ALL: begin
        acc     = enabled;
        clr_all = enabled;
        if (acc) begin
          cnt_new = '0;
        end
      end
      smvs_pkg::OP_QUERY: begin
        acc = vid_ok;
      end
      default: begin
        ok_out = 1'b0;
      end
    endcase
    cmd.en        = cmd.en && fire;
    info.accepted = acc;
    info.rd       = acc && (op == smvs_pkg::OP_READ);
    info.fill     = ok_out ? cnt_new : '0;
    info.cap      = ok_out ? cap_r : '0;
  end

  always_comb begin
    for (int i = 0; i < smvs_pkg::MAX_VECTORS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (cfg_we || (fire && clr_all)) begin
        cnt_nxt[i] = '0;
      end
    end
    if (fire && vid_ok) begin
      cnt_nxt[vector_id] = cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r <= '0;
      cap_r <= '0;
      for (int i = 0; i < smvs_pkg::MAX_VECTORS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        vec_r <= cfg_wdata;
        cap_r <= smvs_pkg::cap_of(cfg_wdata);
      end
      for (int i = 0; i < smvs_pkg::MAX_VECTORS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

/* rtl/segmented_multi_vector_store_core.sv */
// Top level of the segmented multi-vector word store.
// The input channel (in_valid/in_ready) carries one operation per beat: op,
// vector_id, index and value. The result channel (out_valid/out_ready) returns
// exactly one beat per operation with accepted, read_word, fill_count and
// capacity, in order. The configuration port writes vec_count with cfg_we and
// cfg_wdata; the user must write it only while no operation is in flight.
// The block does not enforce this. An operation accepted at an edge updates
// the fill counters at that edge and enters stage s1, then the output register
// when the output can advance. One operation is taken per cycle while in_ready
// is high; the single store port does at most one read or write per operation.
// After reset the block sweeps the 4096-word store to zero, one word a cycle,
// and holds in_ready low until the sweep ends; configuration writes are taken
// throughout. When the receiver stalls, the output register and the one stage
// behind it hold their beats and in_ready drops until the output drains.
`include "segmented_multi_vector_store_core_defines.svh"

module segmented_multi_vector_store_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [smvs_pkg::VEC_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [smvs_pkg::OP_W-1:0]   in_op,
  input  logic [smvs_pkg::VID_W-1:0]  in_vector_id,
  input  logic [smvs_pkg::ADDR_W-1:0] in_index,
  input  logic [smvs_pkg::WORD_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_accepted,
  output logic [smvs_pkg::WORD_W-1:0] out_read_word,
  output logic [smvs_pkg::CNT_W-1:0]  out_fill_count,
  output logic [smvs_pkg::CNT_W-1:0]  out_capacity
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [smvs_pkg::ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic                        s1_valid_r, s1_valid_nxt;
  smvs_pkg::res_info_t         s1_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_accepted_r;
  logic [smvs_pkg::WORD_W-1:0] out_read_word_r;
  logic [smvs_pkg::CNT_W-1:0]  out_fill_count_r;
  logic [smvs_pkg::CNT_W-1:0]  out_capacity_r;

  logic                        adv;
  logic                        fire;
  smvs_pkg::ram_cmd_t          issue_cmd;
  smvs_pkg::ram_cmd_t          ram_cmd;
  smvs_pkg::res_info_t         issue_info;
  logic [smvs_pkg::WORD_W-1:0] ram_rdata;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_RUN) && adv;
  assign fire     = in_valid && in_ready;

  smvs_issue u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .op        (in_op),
    .vector_id (in_vector_id),
    .index     (in_index),
    .value     (in_value),
    .cmd       (issue_cmd),
    .info      (issue_info)
  );

  always_comb begin
    ram_cmd = issue_cmd;
    if (state_r == ST_CLEAR) begin
      ram_cmd.en    = 1'b1;
      ram_cmd.we    = 1'b1;
      ram_cmd.addr  = clr_addr_r;
      ram_cmd.wdata = '0;
    end
  end

  smvs_ram #(
    .WIDTH (smvs_pkg::WORD_W),
    .DEPTH (smvs_pkg::TILE_N)
  ) u_store (
    .clk   (clk),
    .en    (ram_cmd.en),
    .we    (ram_cmd.we),
    .addr  (ram_cmd.addr),
    .wdata (ram_cmd.wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + smvs_pkg::ADDR_W'(1);
        if (&clr_addr_r) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r             <= issue_info;
      out_accepted_r   <= s1_r.accepted;
      out_read_word_r  <= s1_r.rd ? ram_rdata : '0;
      out_fill_count_r <= s1_r.fill;
      out_capacity_r   <= s1_r.cap;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_read_word  = out_read_word_r;
  assign out_fill_count = out_fill_count_r;
  assign out_capacity   = out_capacity_r;

  `SMVS_ASSERT(a_no_accept_in_clear, !((state_r == ST_CLEAR) && fire))
  `SMVS_ASSERT(a_clear_ends_at_top, !((state_r == ST_CLEAR) && (state_nxt == ST_RUN)) || (&clr_addr_r))
  `SMVS_ASSERT_NEXT(a_fire_fills_stage, fire, s1_valid_r)
  `SMVS_ASSERT_NEXT(a_stall_keeps_stage, s1_valid_r && !adv, s1_valid_r && $stable(s1_r))
  `SMVS_ASSERT(a_no_store_access_on_stall, !((state_r == ST_RUN) && !adv && ram_cmd.en))

endmodule

/* test/segmented_multi_vector_store_checker.sv */
// Checker that predicts and compares each result beat of the segmented vector store.
`timescale 1ns / 100ps

module segmented_multi_vector_store_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [smvs_pkg::VEC_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [smvs_pkg::OP_W-1:0]   in_op,
  input  logic [smvs_pkg::VID_W-1:0]  in_vector_id,
  input  logic [smvs_pkg::ADDR_W-1:0] in_index,
  input  logic [smvs_pkg::WORD_W-1:0] in_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_accepted,
  input  logic [smvs_pkg::WORD_W-1:0] out_read_word,
  input  logic [smvs_pkg::CNT_W-1:0]  out_fill_count,
  input  logic [smvs_pkg::CNT_W-1:0]  out_capacity,
  output int                          mismatches,
  output int                          outstanding
);
  import smvs_pkg::*;

  typedef struct packed {
    logic              accepted;
    logic [WORD_W-1:0] read_word;
    logic [CNT_W-1:0]  fill_count;
    logic [CNT_W-1:0]  capacity;
  } store_result_t;

  logic [WORD_W-1:0] word_mem [TILE_N];
  logic [CNT_W-1:0]  fill_level [MAX_VECTORS];
  logic [CNT_W-1:0]  seg_cap = '0;
  int unsigned       live_vectors = 0;
  store_result_t     result_fifo [$];
  int                fail_count = 0;
  int                queued = 0;

  assign mismatches  = fail_count;
  assign outstanding = queued;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
    fail_count++;
  endtask

  function automatic void set_vec_count(input logic [VEC_W-1:0] n);
    for (int v = 0; v < MAX_VECTORS; v++) begin
      fill_level[v] = '0;
    end
    seg_cap = '0;
    live_vectors = 0;
    if (n >= 1 && n <= MAX_VECTORS) begin
      seg_cap = CNT_W'(TILE_N / int'(n));
      if (seg_cap != 0) begin
        live_vectors = n;
      end
    end
  endfunction

  function automatic store_result_t apply_op(input logic [OP_W-1:0] op,
                                             input logic [VID_W-1:0] vid,
                                             input logic [ADDR_W-1:0] idx,
                                             input logic [WORD_W-1:0] val);
    store_result_t r;
    logic vid_ok;
    int slot;
    r = '0;
    vid_ok = (live_vectors != 0) && (vid < live_vectors);
    slot = vid_ok ? int'(vid) * int'(seg_cap) : 0;
    case (op)
      OP_PUSH: begin
        if (vid_ok && fill_level[vid] < seg_cap) begin
          word_mem[slot + int'(fill_level[vid])] = val;
          fill_level[vid] = fill_level[vid] + 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (vid_ok && idx < seg_cap) begin
          r.read_word = word_mem[slot + int'(idx)];
          r.accepted = 1'b1;
        end
      end
      OP_WRITE: begin
        if (vid_ok && idx < seg_cap) begin
          word_mem[slot + int'(idx)] = val;
          if (idx >= fill_level[vid]) begin
            fill_level[vid] = CNT_W'(idx) + 1'b1;
          end
          r.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (vid_ok) begin
          fill_level[vid] = '0;
          r.accepted = 1'b1;
        end
      end
      OP_CLEAR_ALL: begin
        if (live_vectors != 0) begin
          for (int v = 0; v < live_vectors; v++) begin
            fill_level[v] = '0;
          end
          r.accepted = 1'b1;
        end
      end
      OP_QUERY: begin
        if (vid_ok) begin
          r.accepted = 1'b1;
        end
      end
      default: begin
        vid_ok = 1'b0;
      end
    endcase
    if (vid_ok) begin
      r.fill_count = fill_level[vid];
      r.capacity = seg_cap;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    store_result_t want;
    if (!rst_n) begin
      for (int a = 0; a < TILE_N; a++) begin
        word_mem[a] = '0;
      end
      set_vec_count('0);
      result_fifo.delete();
    end else begin
      if (cfg_we) begin
        set_vec_count(cfg_wdata);
      end
      if (in_valid && in_ready) begin
        result_fifo.push_back(apply_op(in_op, in_vector_id, in_index, in_value));
      end
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          report_mismatch("result beat with nothing pending", out_accepted, 0);
        end else begin
          want = result_fifo.pop_front();
          if (out_accepted !== want.accepted) begin
            report_mismatch("accepted", out_accepted, want.accepted);
          end
          if (out_read_word !== want.read_word) begin
            report_mismatch("read_word", out_read_word, want.read_word);
          end
          if (out_fill_count !== want.fill_count) begin
            report_mismatch("fill_count", out_fill_count, want.fill_count);
          end
          if (out_capacity !== want.capacity) begin
            report_mismatch("capacity", out_capacity, want.capacity);
          end
        end
      end
    end
    queued <= result_fifo.size();
  end

endmodule

/* test/segmented_multi_vector_store_core_tb.sv */
// Testbench top for the segmented multi-vector store: stimulus, reset and verdict.
`timescale 1ns / 100ps

module segmented_multi_vector_store_core_tb;
  import smvs_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [VEC_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op = OP_PUSH;
  logic [VID_W-1:0]  in_vector_id = '0;
  logic [ADDR_W-1:0] in_index = '0;
  logic [WORD_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic              out_accepted;
  logic [WORD_W-1:0] out_read_word;
  logic [CNT_W-1:0]  out_fill_count;
  logic [CNT_W-1:0]  out_capacity;
  int                mismatches;
  int                outstanding;

  int unsigned burst_left = 0;
  int unsigned vec_now = 0;
  int unsigned stall_tick = 0;
  int unsigned stall_mode = 0;

  segmented_multi_vector_store_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_vector_id(in_vector_id), .in_index(in_index), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_accepted(out_accepted),
    .out_read_word(out_read_word), .out_fill_count(out_fill_count),
    .out_capacity(out_capacity)
  );

  segmented_multi_vector_store_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_vector_id(in_vector_id), .in_index(in_index), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_accepted(out_accepted),
    .out_read_word(out_read_word), .out_fill_count(out_fill_count),
    .out_capacity(out_capacity), .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 97 == 0) begin
      stall_mode <= $urandom_range(0, 3);
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (stall_tick % 4 == 0);
      default: out_ready <= (stall_tick % 8 < 5);
    endcase
  end

  task automatic write_vec_count(input int unsigned n);
    cfg_we <= 1'b1;
    cfg_wdata <= VEC_W'(n);
    vec_now = n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input int unsigned vid,
                         input int unsigned idx, input int unsigned val);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_vector_id <= VID_W'(vid);
    in_index <= ADDR_W'(idx);
    in_value <= WORD_W'(val);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_op();
    logic [OP_W-1:0] op;
    int unsigned vid;
    int unsigned idx;
    int unsigned cap;
    int unsigned pick;
    cap = (vec_now >= 1 && vec_now <= MAX_VECTORS) ? TILE_N / vec_now : 0;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      op = OP_PUSH;
    end else if (pick < 55) begin
      op = OP_READ;
    end else if (pick < 75) begin
      op = OP_WRITE;
    end else if (pick < 82) begin
      op = OP_CLEAR;
    end else if (pick < 85) begin
      op = OP_CLEAR_ALL;
    end else if (pick < 95) begin
      op = OP_QUERY;
    end else begin
      op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    end
    pick = $urandom_range(0, 9);
    if (cap != 0 && pick < 3) begin
      vid = 0;
    end else if (cap != 0 && pick < 9) begin
      vid = $urandom_range(0, vec_now - 1);
    end else begin
      vid = $urandom_range(0, MAX_VECTORS - 1);
    end
    pick = $urandom_range(0, 9);
    if (cap == 0 || pick == 2) begin
      idx = $urandom_range(0, TILE_N - 1);
    end else if (pick == 0) begin
      idx = cap - 1;
    end else if (pick == 1) begin
      idx = (cap < TILE_N) ? cap : TILE_N - 1;
    end else if (pick == 3) begin
      idx = 0;
    end else begin
      idx = $urandom_range(0, cap - 1);
    end
    send_op(op, vid, idx, $urandom_range(0, 65535));
  endtask

  initial begin
    int unsigned phase_vec [10];
    int unsigned count;
    phase_vec = '{2, 16, 3, 17, 1, 5, 31, 7, 9, 4};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_vec_count(0);
    send_op(OP_PUSH, 0, 0, 16'h1234);
    send_op(OP_READ, 0, 0, 0);
    send_op(OP_CLEAR_ALL, 0, 0, 0);
    send_op(OP_SPARE_LO, 3, 7, 16'hffff);
    wait_drained();

    write_vec_count(MAX_VECTORS);
    send_op(OP_PUSH, 0, 0, 16'hffff);
    send_op(OP_PUSH, 15, 0, 16'h0000);
    send_op(OP_READ, 15, 0, 0);
    send_op(OP_READ, 0, 255, 0);
    send_op(OP_READ, 0, 256, 0);
    send_op(OP_READ, 0, 4095, 0);
    send_op(OP_WRITE, 3, 255, 16'haaaa);
    send_op(OP_PUSH, 3, 0, 16'h5555);
    send_op(OP_WRITE, 3, 10, 16'h5555);
    send_op(OP_CLEAR, 3, 0, 0);
    send_op(OP_QUERY, 3, 0, 0);
    send_op(OP_CLEAR_ALL, 0, 0, 0);
    send_op(OP_QUERY, 15, 0, 0);
    send_op(OP_SPARE_HI, 15, 4095, 16'hffff);
    wait_drained();

    write_vec_count(1);
    send_op(OP_WRITE, 0, 4095, 16'h0005);
    send_op(OP_READ, 0, 4095, 0);
    send_op(OP_PUSH, 1, 0, 16'h00ff);
    send_op(OP_CLEAR_ALL, 9, 0, 0);
    send_op(OP_QUERY, 0, 0, 0);
    wait_drained();

    foreach (phase_vec[p]) begin
      write_vec_count(phase_vec[p]);
      count = (phase_vec[p] >= 1 && phase_vec[p] <= MAX_VECTORS) ? 180 : 30;
      repeat (count) random_op();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
